@@ hw/rtl/tpc_pkg.sv @@
package tpc_pkg;

  localparam int CoordW   = 32;
  localparam int PlaneW   = 32;
  localparam int FracBits = 16;
  localparam int ProdW    = CoordW + PlaneW;
  localparam int DistW    = CoordW + PlaneW - FracBits + 1;
  localparam int DenW     = DistW;
  localparam int DaW      = DistW - 1;
  localparam int DaLoW    = DaW / 2;
  localparam int DaHiW    = DaW - DaLoW;
  localparam int DivW     = CoordW + DaW;
  localparam int DivSteps = CoordW;

  localparam logic [PlaneW-1:0] NormalZReset = PlaneW'(64'd1 << FracBits);

  typedef enum logic [1:0] {
    REG_NX,
    REG_NY,
    REG_NZ,
    REG_OFFSET
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ALL,
    MODE_ONE,
    MODE_TWO
  } mode_e;

  typedef logic [2:0][CoordW-1:0] vtx_t;

  typedef struct packed {
    logic [DenW-1:0]   rem;
    logic [CoordW-1:0] lq;
    logic [CoordW-1:0] base;
    logic              neg;
  } lane_t;

  typedef struct packed {
    logic [DenW-1:0] den;
    lane_t [2:0]     lane;
  } cross_t;

  typedef struct packed {
    mode_e             mode;
    vtx_t              sa;
    vtx_t              sb;
    vtx_t              sc;
    logic [CoordW-1:0] color;
  } pay_t;

  typedef struct packed {
    pay_t         pay;
    cross_t [1:0] cr;
  } work_t;

endpackage

@@ hw/rtl/triangle_plane_clipper_core.sv @@
// A triangle not wholly outside the plane strobes a result after passing the distance, setup,
// divider and output registers; a second result of the same triangle follows in the next cycle.
// Throughput: one triangle per cycle through a 40-stage pipeline (32 stages of it are the
// one-bit-per-stage edge divider); a triangle that yields two results holds busy for one cycle.
// Reset: asynchronous, active low; empties the pipeline and loads the plane registers.
module triangle_plane_clipper_core import tpc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] in_ax_i,
  input  logic signed [CoordW-1:0] in_ay_i,
  input  logic signed [CoordW-1:0] in_az_i,
  input  logic signed [CoordW-1:0] in_bx_i,
  input  logic signed [CoordW-1:0] in_by_i,
  input  logic signed [CoordW-1:0] in_bz_i,
  input  logic signed [CoordW-1:0] in_cx_i,
  input  logic signed [CoordW-1:0] in_cy_i,
  input  logic signed [CoordW-1:0] in_cz_i,
  input  logic [CoordW-1:0]        in_color_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [PlaneW-1:0]        cfg_data_i,
  output logic                     out_valid_o,
  output logic signed [CoordW-1:0] out_ax_o,
  output logic signed [CoordW-1:0] out_ay_o,
  output logic signed [CoordW-1:0] out_az_o,
  output logic signed [CoordW-1:0] out_bx_o,
  output logic signed [CoordW-1:0] out_by_o,
  output logic signed [CoordW-1:0] out_bz_o,
  output logic signed [CoordW-1:0] out_cx_o,
  output logic signed [CoordW-1:0] out_cy_o,
  output logic signed [CoordW-1:0] out_cz_o,
  output logic [CoordW-1:0]        out_color_o,
  output logic                     out_last_o
);

  logic [2:0][PlaneW-1:0] normal_q;
  logic [PlaneW-1:0]      offset_q;
  logic                   adv;
  vtx_t [2:0]             in_vtx;
  logic                   ds_valid;
  vtx_t [2:0]             ds_vtx;
  logic [2:0][DistW-1:0]  ds_dist;
  logic [CoordW-1:0]      ds_color;
  logic                   stg_valid [DivSteps+1];
  work_t                  stg_work [DivSteps+1];
  vtx_t [2:0]             out_vtx;

  assign cfg_ready_o = 1'b1;
  assign adv         = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q[0] <= '0;
      normal_q[1] <= '0;
      normal_q[2] <= NormalZReset;
      offset_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_NX:     normal_q[0] <= cfg_data_i;
        REG_NY:     normal_q[1] <= cfg_data_i;
        REG_NZ:     normal_q[2] <= cfg_data_i;
        REG_OFFSET: offset_q    <= cfg_data_i;
      endcase
    end
  end

  assign in_vtx[0] = {in_az_i, in_ay_i, in_ax_i};
  assign in_vtx[1] = {in_bz_i, in_by_i, in_bx_i};
  assign in_vtx[2] = {in_cz_i, in_cy_i, in_cx_i};

  tpc_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (start && !busy),
    .vtx_i    (in_vtx),
    .color_i  (in_color_i),
    .normal_i (normal_q),
    .offset_i (offset_q),
    .valid_o  (ds_valid),
    .vtx_o    (ds_vtx),
    .dist_o   (ds_dist),
    .color_o  (ds_color)
  );

  tpc_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (ds_valid),
    .vtx_i   (ds_vtx),
    .dist_i  (ds_dist),
    .color_i (ds_color),
    .valid_o (stg_valid[0]),
    .work_o  (stg_work[0])
  );

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    tpc_div_stage u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (stg_valid[s]),
      .work_i  (stg_work[s]),
      .valid_o (stg_valid[s+1]),
      .work_o  (stg_work[s+1])
    );
  end

  tpc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stg_valid[DivSteps]),
    .work_i      (stg_work[DivSteps]),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_last_o  (out_last_o),
    .out_vtx_o   (out_vtx),
    .out_color_o (out_color_o)
  );

  assign out_ax_o = out_vtx[0][0];
  assign out_ay_o = out_vtx[0][1];
  assign out_az_o = out_vtx[0][2];
  assign out_bx_o = out_vtx[1][0];
  assign out_by_o = out_vtx[1][1];
  assign out_bz_o = out_vtx[1][2];
  assign out_cx_o = out_vtx[2][0];
  assign out_cy_o = out_vtx[2][1];
  assign out_cz_o = out_vtx[2][2];

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (out_valid_o && !out_last_o))
    else $error("busy without a first triangle on the result ports");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_last_o) |=> (out_valid_o && out_last_o))
    else $error("first triangle not followed by the final one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held for more than one cycle");
`endif

endmodule

@@ hw/rtl/tpc_dist.sv @@
module tpc_dist import tpc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  vtx_t [2:0]             vtx_i,
  input  logic [CoordW-1:0]      color_i,
  input  logic [2:0][PlaneW-1:0] normal_i,
  input  logic [PlaneW-1:0]      offset_i,
  output logic                   valid_o,
  output vtx_t [2:0]             vtx_o,
  output logic [2:0][DistW-1:0]  dist_o,
  output logic [CoordW-1:0]      color_o
);

  logic                        in_valid_q;
  vtx_t [2:0]                  in_vtx_q;
  logic [CoordW-1:0]           in_color_q;
  logic                        pr_valid_q;
  vtx_t [2:0]                  pr_vtx_q;
  logic [CoordW-1:0]           pr_color_q;
  logic [2:0][2:0][ProdW-1:0]  prod_d, prod_q;
  logic                        ds_valid_q;
  vtx_t [2:0]                  ds_vtx_q;
  logic [CoordW-1:0]           ds_color_q;
  logic [2:0][DistW-1:0]       dist_d, dist_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = ProdW'($signed(ProdW'($signed(normal_i[j])))
                              * $signed(ProdW'($signed(in_vtx_q[i][j]))));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dist_d[i] = DistW'($signed(offset_i))
                + DistW'($signed(prod_q[i][0]) >>> FracBits)
                + DistW'($signed(prod_q[i][1]) >>> FracBits)
                + DistW'($signed(prod_q[i][2]) >>> FracBits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pr_valid_q <= 1'b0;
      ds_valid_q <= 1'b0;
    end else if (adv_i) begin
      in_valid_q <= valid_i;
      pr_valid_q <= in_valid_q;
      ds_valid_q <= pr_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      in_vtx_q   <= vtx_i;
      in_color_q <= color_i;
      pr_vtx_q   <= in_vtx_q;
      pr_color_q <= in_color_q;
      prod_q     <= prod_d;
      ds_vtx_q   <= pr_vtx_q;
      ds_color_q <= pr_color_q;
      dist_q     <= dist_d;
    end
  end

  assign valid_o = ds_valid_q;
  assign vtx_o   = ds_vtx_q;
  assign dist_o  = dist_q;
  assign color_o = ds_color_q;

endmodule

@@ hw/rtl/tpc_setup.sv @@
module tpc_setup import tpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  vtx_t [2:0]            vtx_i,
  input  logic [2:0][DistW-1:0] dist_i,
  input  logic [CoordW-1:0]     color_i,
  output logic                  valid_o,
  output work_t                 work_o
);

  logic [2:0]                         in_mask;
  mode_e                              mode;
  logic [1:0][1:0]                    xa, xb;
  pay_t                               pay_d;
  logic [1:0][DenW-1:0]               den_d;
  logic [1:0][DaW-1:0]                da_d;
  logic [1:0][2:0][CoordW:0]          diff;
  logic [1:0][2:0][CoordW-1:0]        mag_d, base_d;
  logic [1:0][2:0]                    neg_d;

  logic                               a_valid_q;
  pay_t                               a_pay_q;
  logic [1:0][DenW-1:0]               a_den_q;
  logic [1:0][DaW-1:0]                a_da_q;
  logic [1:0][2:0][CoordW-1:0]        a_mag_q, a_base_q;
  logic [1:0][2:0]                    a_neg_q;

  logic [1:0][2:0][CoordW+DaLoW-1:0]  plo_d, b_plo_q;
  logic [1:0][2:0][CoordW+DaHiW-1:0]  phi_d, b_phi_q;
  logic                               b_valid_q;
  pay_t                               b_pay_q;
  logic [1:0][DenW-1:0]               b_den_q;
  logic [1:0][2:0][CoordW-1:0]        b_base_q;
  logic [1:0][2:0]                    b_neg_q;

  logic [1:0][2:0][DivW-1:0]          dvd;
  work_t                              work_d, work_q;
  logic                               c_valid_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_mask[i] = !dist_i[i][DistW-1];
    end
    mode  = MODE_NONE;
    xa[0] = 2'd0;
    xb[0] = 2'd1;
    xa[1] = 2'd1;
    xb[1] = 2'd2;
    unique case (in_mask)
      3'b000: mode = MODE_NONE;
      3'b111: mode = MODE_ALL;
      3'b001: begin
        mode = MODE_ONE; xa[0] = 2'd0; xb[0] = 2'd1; xa[1] = 2'd0; xb[1] = 2'd2;
      end
      3'b010: begin
        mode = MODE_ONE; xa[0] = 2'd1; xb[0] = 2'd0; xa[1] = 2'd1; xb[1] = 2'd2;
      end
      3'b100: begin
        mode = MODE_ONE; xa[0] = 2'd2; xb[0] = 2'd0; xa[1] = 2'd2; xb[1] = 2'd1;
      end
      3'b011: begin
        mode = MODE_TWO; xa[0] = 2'd0; xb[0] = 2'd2; xa[1] = 2'd1; xb[1] = 2'd2;
      end
      3'b101: begin
        mode = MODE_TWO; xa[0] = 2'd0; xb[0] = 2'd1; xa[1] = 2'd2; xb[1] = 2'd1;
      end
      3'b110: begin
        mode = MODE_TWO; xa[0] = 2'd1; xb[0] = 2'd0; xa[1] = 2'd2; xb[1] = 2'd0;
      end
    endcase

    pay_d.mode  = mode;
    pay_d.sa    = vtx_i[xa[0]];
    pay_d.sb    = vtx_i[xa[1]];
    pay_d.sc    = vtx_i[2];
    pay_d.color = color_i;

    for (int k = 0; k < 2; k++) begin
      den_d[k] = DenW'($signed(dist_i[xa[k]]) - $signed(dist_i[xb[k]]));
      da_d[k]  = dist_i[xa[k]][DaW-1:0];
      for (int j = 0; j < 3; j++) begin
        diff[k][j]   = (CoordW+1)'($signed(vtx_i[xb[k]][j]))
                     - (CoordW+1)'($signed(vtx_i[xa[k]][j]));
        neg_d[k][j]  = diff[k][j][CoordW];
        mag_d[k][j]  = neg_d[k][j] ? CoordW'(-diff[k][j]) : diff[k][j][CoordW-1:0];
        base_d[k][j] = vtx_i[xa[k]][j];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 3; j++) begin
        plo_d[k][j] = (CoordW+DaLoW)'(a_mag_q[k][j])
                    * (CoordW+DaLoW)'(a_da_q[k][DaLoW-1:0]);
        phi_d[k][j] = (CoordW+DaHiW)'(a_mag_q[k][j])
                    * (CoordW+DaHiW)'(a_da_q[k][DaW-1:DaLoW]);
      end
    end
  end

  always_comb begin
    work_d.pay = b_pay_q;
    for (int k = 0; k < 2; k++) begin
      work_d.cr[k].den = b_den_q[k];
      for (int j = 0; j < 3; j++) begin
        dvd[k][j] = DivW'(b_plo_q[k][j]) + (DivW'(b_phi_q[k][j]) << DaLoW);
        work_d.cr[k].lane[j].rem  = DenW'(dvd[k][j][DivW-1:CoordW]);
        work_d.cr[k].lane[j].lq   = dvd[k][j][CoordW-1:0];
        work_d.cr[k].lane[j].base = b_base_q[k][j];
        work_d.cr[k].lane[j].neg  = b_neg_q[k][j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i && (mode != MODE_NONE);
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_pay_q  <= pay_d;
      a_den_q  <= den_d;
      a_da_q   <= da_d;
      a_mag_q  <= mag_d;
      a_base_q <= base_d;
      a_neg_q  <= neg_d;
      b_pay_q  <= a_pay_q;
      b_den_q  <= a_den_q;
      b_plo_q  <= plo_d;
      b_phi_q  <= phi_d;
      b_base_q <= a_base_q;
      b_neg_q  <= a_neg_q;
      work_q   <= work_d;
    end
  end

  assign valid_o = c_valid_q;
  assign work_o  = work_q;

endmodule

@@ hw/rtl/tpc_div_stage.sv @@
module tpc_div_stage import tpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  valid_i,
  input  work_t work_i,
  output logic  valid_o,
  output work_t work_o
);

  logic [1:0][2:0][DenW:0] trial;
  logic [1:0][2:0]         ge;
  work_t                   work_d, work_q;
  logic                    valid_q;

  always_comb begin
    work_d = work_i;
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 3; j++) begin
        trial[k][j] = {work_i.cr[k].lane[j].rem, work_i.cr[k].lane[j].lq[CoordW-1]};
        ge[k][j]    = trial[k][j] >= {1'b0, work_i.cr[k].den};
        work_d.cr[k].lane[j].rem = ge[k][j]
            ? DenW'(trial[k][j] - {1'b0, work_i.cr[k].den})
            : DenW'(trial[k][j]);
        work_d.cr[k].lane[j].lq = {work_i.cr[k].lane[j].lq[CoordW-2:0], ge[k][j]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

@@ hw/rtl/tpc_out.sv @@
module tpc_out import tpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  work_t             work_i,
  output logic              busy_o,
  output logic              out_valid_o,
  output logic              out_last_o,
  output vtx_t [2:0]        out_vtx_o,
  output logic [CoordW-1:0] out_color_o
);

  typedef struct packed {
    vtx_t p0;
    vtx_t p1;
    vtx_t p2;
  } tri_t;

  function automatic logic [CoordW-1:0] sat_coord(input logic [CoordW+1:0] s);
    logic [CoordW-1:0] r;
    if (s[CoordW+1:CoordW-1] == '0 || s[CoordW+1:CoordW-1] == '1) begin
      r = s[CoordW-1:0];
    end else if (s[CoordW+1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

  logic [1:0][2:0][CoordW+1:0] ext_base, ext_q, sum;
  vtx_t [1:0]                  xv;
  tri_t                        tri0_d, tri1_d;
  logic                        two_d;

  logic                        fx_valid_q, fx_two_q;
  tri_t                        fx_tri0_q, fx_tri1_q;
  logic [CoordW-1:0]           fx_color_q;

  logic                        pend_q, out_valid_q, out_last_q;
  tri_t                        out_tri_q, sec_tri_q;
  logic [CoordW-1:0]           out_color_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 3; j++) begin
        ext_base[k][j] = {{2{work_i.cr[k].lane[j].base[CoordW-1]}},
                          work_i.cr[k].lane[j].base};
        ext_q[k][j]    = {2'b00, work_i.cr[k].lane[j].lq};
        sum[k][j]      = work_i.cr[k].lane[j].neg ? ext_base[k][j] - ext_q[k][j]
                                                  : ext_base[k][j] + ext_q[k][j];
        xv[k][j]       = sat_coord(sum[k][j]);
      end
    end
  end

  always_comb begin
    tri0_d = '{p0: work_i.pay.sa, p1: work_i.pay.sb, p2: work_i.pay.sc};
    tri1_d = '{p0: work_i.pay.sb, p1: xv[0], p2: xv[1]};
    two_d  = 1'b0;
    unique case (work_i.pay.mode)
      MODE_ONE: tri0_d = '{p0: work_i.pay.sa, p1: xv[0], p2: xv[1]};
      MODE_TWO: begin
        tri0_d = '{p0: work_i.pay.sa, p1: work_i.pay.sb, p2: xv[0]};
        two_d  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_valid_q  <= 1'b0;
      fx_two_q    <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (pend_q) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b1;
      out_last_q  <= 1'b1;
    end else begin
      fx_valid_q  <= valid_i;
      fx_two_q    <= two_d;
      pend_q      <= fx_valid_q && fx_two_q;
      out_valid_q <= fx_valid_q;
      out_last_q  <= !fx_two_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_tri_q <= sec_tri_q;
    end else begin
      fx_tri0_q   <= tri0_d;
      fx_tri1_q   <= tri1_d;
      fx_color_q  <= work_i.pay.color;
      out_tri_q   <= fx_tri0_q;
      sec_tri_q   <= fx_tri1_q;
      out_color_q <= fx_color_q;
    end
  end

  assign busy_o       = pend_q;
  assign out_valid_o  = out_valid_q;
  assign out_last_o   = out_last_q;
  assign out_vtx_o[0] = out_tri_q.p0;
  assign out_vtx_o[1] = out_tri_q.p1;
  assign out_vtx_o[2] = out_tri_q.p2;
  assign out_color_o  = out_color_q;

endmodule

@@ verif/tb_triangle_plane_clipper_core.sv @@
module tb_triangle_plane_clipper_core import tpc_pkg::*;;

  typedef logic [31:0] tri_in_t [10];

  typedef struct {
    longint      crd[9];
    logic [31:0] color;
    logic        last;
  } clip_tri_t;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 45;

  class clip_scoreboard;
    longint    nrm[3];
    longint    ofs;
    clip_tri_t pending[$];
    int        errors;
    int        checked;

    function new();
      nrm[0] = 0;
      nrm[1] = 0;
      nrm[2] = 65536;
      ofs = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_plane(reg_idx_e idx, logic [31:0] val);
      if (idx == REG_OFFSET) ofs = longint'($signed(val));
      else nrm[idx] = longint'($signed(val));
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint plane_dist(longint x, longint y, longint z);
      return ofs + ((nrm[0] * x) >>> FracBits) + ((nrm[1] * y) >>> FracBits)
             + ((nrm[2] * z) >>> FracBits);
    endfunction

    function longint edge_coord(longint a, longint b, longint da, longint db);
      longint       diff;
      logic [127:0] mag;
      logic [127:0] den;
      logic [127:0] quo;
      longint       q;
      diff = b - a;
      mag = diff < 0 ? 128'(-diff) : 128'(diff);
      den = 128'(da - db);
      quo = (den == 0) ? 128'd0 : (mag * 128'(da)) / den;
      q = longint'(quo[63:0]);
      return sat32(a + (diff < 0 ? -q : q));
    endfunction

    function void push_tri(longint p[3], longint r[3], longint s[3], logic [31:0] col,
                           logic lst);
      clip_tri_t t;
      for (int j = 0; j < 3; j++) begin
        t.crd[j] = sat32(p[j]);
        t.crd[3+j] = sat32(r[j]);
        t.crd[6+j] = sat32(s[j]);
      end
      t.color = col;
      t.last = lst;
      pending.insert(pending.size(), t);
    endfunction

    function void note_triangle(tri_in_t f);
      longint v[3][3];
      longint d[3];
      longint x0[3];
      longint x1[3];
      int     ins[3];
      int     outs[3];
      int     n_in;
      int     n_out;
      n_in = 0;
      n_out = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) v[i][j] = longint'($signed(f[i*3+j]));
        d[i] = plane_dist(v[i][0], v[i][1], v[i][2]);
        if (d[i] >= 0) begin
          ins[n_in] = i;
          n_in++;
        end else begin
          outs[n_out] = i;
          n_out++;
        end
      end
      case (n_in)
        3: push_tri(v[0], v[1], v[2], f[9], 1'b1);
        1: begin
          for (int j = 0; j < 3; j++) begin
            x0[j] = edge_coord(v[ins[0]][j], v[outs[0]][j], d[ins[0]], d[outs[0]]);
            x1[j] = edge_coord(v[ins[0]][j], v[outs[1]][j], d[ins[0]], d[outs[1]]);
          end
          push_tri(v[ins[0]], x0, x1, f[9], 1'b1);
        end
        2: begin
          for (int j = 0; j < 3; j++) begin
            x0[j] = edge_coord(v[ins[0]][j], v[outs[0]][j], d[ins[0]], d[outs[0]]);
            x1[j] = edge_coord(v[ins[1]][j], v[outs[0]][j], d[ins[1]], d[outs[0]]);
          end
          push_tri(v[ins[0]], v[ins[1]], x0, f[9], 1'b0);
          push_tri(v[ins[1]], x0, x1, f[9], 1'b1);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(clip_tri_t got);
      clip_tri_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, colour", got.color, 0);
        return;
      end
      want = pending[0];
      pending.delete(0);
      checked++;
      for (int k = 0; k < 9; k++)
        if (got.crd[k] != want.crd[k])
          report_mismatch($sformatf("coord %0d", k), got.crd[k], want.crd[k]);
      if (got.color != want.color) report_mismatch("colour", got.color, want.color);
      if (got.last != want.last) report_mismatch("last", got.last, want.last);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic signed [CoordW-1:0] in_ax_i, in_ay_i, in_az_i, in_bx_i, in_by_i, in_bz_i;
  logic signed [CoordW-1:0] in_cx_i, in_cy_i, in_cz_i;
  logic [CoordW-1:0] in_color_i;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [PlaneW-1:0] cfg_data_i;
  logic out_valid_o;
  logic signed [CoordW-1:0] out_ax_o, out_ay_o, out_az_o, out_bx_o, out_by_o, out_bz_o;
  logic signed [CoordW-1:0] out_cx_o, out_cy_o, out_cz_o;
  logic [CoordW-1:0] out_color_o;
  logic out_last_o;

  triangle_plane_clipper_core u_dut (.*);

  clip_scoreboard sb = new();
  int sent_tris;
  int plane_count;
  int idle_pct;
  int stall_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    clip_tri_t got;
    if (rst_ni && out_valid_o) begin
      got.crd = '{longint'(out_ax_o), longint'(out_ay_o), longint'(out_az_o),
                  longint'(out_bx_o), longint'(out_by_o), longint'(out_bz_o),
                  longint'(out_cx_o), longint'(out_cy_o), longint'(out_cz_o)};
      got.color = out_color_o;
      got.last = out_last_o;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_valid_o || (cfg_valid_i && cfg_ready_o))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("Timeout: no transaction for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_tri(tri_in_t f);
    int gap;
    {in_ax_i, in_ay_i, in_az_i} <= {f[0], f[1], f[2]};
    {in_bx_i, in_by_i, in_bz_i} <= {f[3], f[4], f[5]};
    {in_cx_i, in_cy_i, in_cz_i} <= {f[6], f[7], f[8]};
    in_color_i <= f[9];
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_triangle(f);
    sent_tris++;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_plane(idx, val);
  endtask

  task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                           logic [31:0] d);
    write_reg(REG_NX, nx);
    write_reg(REG_NY, ny);
    write_reg(REG_NZ, nz);
    write_reg(REG_OFFSET, d);
    cfg_valid_i <= 1'b0;
    plane_count++;
  endtask

  function automatic logic [31:0] rand_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    if (pick < 85) return $urandom();
    case ($urandom_range(4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic tri_in_t rand_tri();
    tri_in_t f;
    for (int k = 0; k < 9; k++) f[k] = rand_coord();
    f[9] = $urandom();
    return f;
  endfunction

  function automatic logic [31:0] rand_small();
    return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
  endfunction

  initial begin
    tri_in_t f;
    int zsel;
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_NX;
    cfg_data_i = '0;
    {in_ax_i, in_ay_i, in_az_i, in_bx_i, in_by_i, in_bz_i} = '0;
    {in_cx_i, in_cy_i, in_cz_i, in_color_i} = '0;
    sent_tris = 0;
    plane_count = 0;
    idle_pct = 0;
    stall_cnt = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset plane z >= 0: every inside/outside pattern, zero distance, extremes
    for (int m = 0; m < 8; m++) begin
      f = rand_tri();
      for (int i = 0; i < 3; i++)
        f[i*3+2] = m[i] ? 32'($signed($urandom_range(1, 32'h0010_0000)))
                        : -32'($signed($urandom_range(1, 32'h0010_0000)));
      send_tri(f);
    end
    f = rand_tri();
    f[2] = '0; f[5] = 32'hffff_0000; f[8] = 32'hffff_ffff;
    send_tri(f);
    f = rand_tri();
    f[2] = '0; f[5] = '0; f[8] = '0;
    send_tri(f);
    for (int k = 0; k < 10; k++) f[k] = 32'h7fff_ffff;
    send_tri(f);
    for (int k = 0; k < 10; k++) f[k] = 32'h8000_0000;
    f[9] = '0;
    send_tri(f);
    for (int m = 0; m < 6; m++) begin
      for (int k = 0; k < 9; k++) f[k] = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      f[9] = $urandom();
      zsel = $urandom_range(2);
      f[zsel*3+2] = (m < 3) ? 32'h7fff_ffff : 32'h8000_0000;
      send_tri(f);
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_plane(32'h0, 32'h0, 32'h0001_0000, 32'h0);
        1: set_plane(32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 32'h7fff_ffff);
        2: set_plane(32'h0001_0000, 32'hffff_0000, 32'h0, 32'h8000_0000);
        3: set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        7: set_plane($urandom(), $urandom(), $urandom(), $urandom());
        default: set_plane(rand_small(), rand_small(), rand_small(), rand_small());
      endcase
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 71;
        2: idle_pct = 0;
        default: idle_pct = 37;
      endcase
      repeat (70) send_tri(rand_tri());
      drain();
    end

    $display("Sent %0d triangles over %0d plane settings plus the reset plane", sent_tris,
             plane_count);
    $display("Checked %0d clipped triangles, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
